[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used in the core modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/ssb_pkg.sv]
// ----------------------------------------------------------------------------
// ssb_pkg
// Types and fixed constants shared by the sprite blit framebuffer core.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int KIND_W   = 2;
  localparam int ROW_W    = 32;
  localparam int ROWIDX_W = 4;
  localparam int COLOFF_W = 9;
  localparam int PAGEOFF_W = 3;
  localparam int RADDR_W  = 10;
  localparam int BYTE_W   = 8;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic draw_start;
    logic draw_step;
    logic read_issue;
    logic out_load;
  } ssb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic draw_last;
    logic out_busy;
  } ssb_sts_t;

endpackage

[rtl/core/ssb_if.sv]
// ----------------------------------------------------------------------------
// ssb_if
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ssb_req_if import ssb_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [KIND_W-1:0]           kind;
  logic [ROW_W-1:0]            row_bits;
  logic [ROWIDX_W-1:0]         row_index;
  logic signed [COLOFF_W-1:0]  column_offset;
  logic [PAGEOFF_W-1:0]        page_offset;
  logic [RADDR_W-1:0]          read_address;

  modport source (output valid, kind, row_bits, row_index, column_offset, page_offset,
                  read_address, input ready);
  modport sink (input valid, kind, row_bits, row_index, column_offset, page_offset,
                read_address, output ready);
endinterface

interface ssb_rsp_if import ssb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

[rtl/core/ssb_ctrl.sv]
// ----------------------------------------------------------------------------
// ssb_ctrl
// Sequencer for clear sweeps, draw sweeps and single byte reads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssb_ctrl import ssb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ssb_req_if.sink   req,
  output ssb_cmd_t  cmd,
  input  ssb_sts_t  sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DRAW  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    cmd.clear_start = accept && (req.kind == KIND_CLEAR);
    cmd.draw_start  = accept && (req.kind == KIND_DRAW);
    cmd.read_issue  = accept && (req.kind == KIND_READ);
    cmd.clear_step  = (state == S_CLEAR);
    cmd.draw_step   = (state == S_DRAW);
    cmd.out_load    = (state == S_READ) && !sts.out_busy;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.clear_start) state_next = S_CLEAR;
        else if (cmd.draw_start) state_next = S_DRAW;
        else if (cmd.read_issue) state_next = S_READ;
      end
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_DRAW: begin
        if (sts.draw_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_IDLE;
      end
      S_READ: begin
        if (cmd.out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // The last column of a row must always be followed by the write-back cycle.
  `ASSERT_NXT(a_draw_drain, clk, rst, state == S_DRAW && sts.draw_last, state == S_DRAIN)
  // A read request leaves the controller waiting to hand over its byte.
  `ASSERT_NXT(a_read_wait, clk, rst, cmd.read_issue, state == S_READ)

endmodule

[rtl/core/ssb_datapath.sv]
// ----------------------------------------------------------------------------
// ssb_datapath
// Framebuffer memory, sweep counters, draw address pipeline and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssb_datapath import ssb_pkg::*; #(
  parameter int PAGES        = 8,
  parameter int COLUMNS      = 128,
  parameter int SPRITE_WIDTH = 32,
  parameter int SPRITE_ROWS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  ssb_req_if.sink   req,
  ssb_rsp_if.source rsp,
  input  ssb_cmd_t  cmd,
  output ssb_sts_t  sts
);

  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = $clog2(COLUMNS);
  localparam int XW     = $clog2(SPRITE_WIDTH);
  localparam int JW     = XW + 1;
  localparam int PX_W   = 11;
  localparam int PG_W   = 5;
  localparam logic [JW-1:0]     LAST_J    = JW'(2 * SPRITE_WIDTH - 1);
  localparam logic [XW-1:0]     LAST_X    = XW'(SPRITE_WIDTH - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [BYTE_W-1:0] mem [DEPTH];

  // Captured draw request.
  logic [ROW_W-1:0]           bits_q;
  logic [ROWIDX_W-1:0]        y_q;
  logic signed [COLOFF_W-1:0] col0_q;
  logic [PAGEOFF_W-1:0]       page_q;

  logic [ADDR_W-1:0] clr_cnt;
  logic [JW-1:0]     j_cnt;

  logic [SPRITE_WIDTH-1:0] pix_vec;
  logic [XW-1:0]           pix_idx;
  logic signed [PX_W-1:0]  px;
  logic [PG_W-1:0]         page_num;
  logic                    col_ok;
  logic                    page_ok;
  logic                    row_ok;
  logic                    wr_en0;
  logic [ADDR_W-1:0]       addr0;
  logic [BYTE_W-1:0]       mask;

  logic              wr_en1;
  logic [ADDR_W-1:0] addr1;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rdata;
  logic              rd_ok;
  logic              out_valid;
  logic [BYTE_W-1:0] out_data;

  always_ff @(posedge clk) begin
    if (cmd.draw_start) begin
      bits_q <= req.row_bits;
      y_q    <= req.row_index;
      col0_q <= req.column_offset;
      page_q <= req.page_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.draw_start) begin
      j_cnt <= '0;
    end else if (cmd.draw_step) begin
      j_cnt <= j_cnt + 1'b1;
    end
  end

  // Pixels above the 32-bit row field read as zero.
  assign pix_vec  = SPRITE_WIDTH'(bits_q);
  assign pix_idx  = LAST_X - j_cnt[JW-1:1];
  assign px       = PX_W'(col0_q) + PX_W'({1'b0, j_cnt});
  assign col_ok   = !px[PX_W-1] && (px < PX_W'(COLUMNS));
  assign page_num = PG_W'(page_q) + PG_W'(y_q[ROWIDX_W-1:2]);
  assign page_ok  = page_num < PAGES;
  assign row_ok   = y_q < SPRITE_ROWS;
  assign mask     = BYTE_W'(2'b11) << {y_q[1:0], 1'b0};
  assign addr0    = ADDR_W'(page_num * COLUMNS) + ADDR_W'(px[CW-1:0]);
  assign wr_en0   = cmd.draw_step && row_ok && pix_vec[pix_idx] && col_ok && page_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en1 <= 1'b0;
    end else begin
      wr_en1 <= wr_en0;
    end
    addr1 <= addr0;
  end

  assign rd_en   = cmd.draw_step || cmd.read_issue;
  assign rd_addr = cmd.draw_step ? addr0 : ADDR_W'(req.read_address);

  always_ff @(posedge clk) begin
    if (cmd.read_issue) begin
      rd_ok <= req.read_address < DEPTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en1) begin
      mem[addr1] <= rdata | mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data <= rd_ok ? rdata : '0;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  always_comb begin
    sts.clear_last = (clr_cnt == LAST_ADDR);
    sts.draw_last  = (j_cnt == LAST_J);
    sts.out_busy   = out_valid && !rsp.ready;
  end

  // The write-back stage must never collide with the clearing sweep.
  `ASSERT_IMP(a_no_wr_clash, clk, rst, wr_en1, !cmd.clear_step)
  // A loaded result is presented on the next cycle.
  `ASSERT_NXT(a_out_loaded, clk, rst, cmd.out_load, rsp.valid)

endmodule

[rtl/core/scaled_sprite_blit_page_framebuffer.sv]
// ----------------------------------------------------------------------------
// scaled_sprite_blit_page_framebuffer
// Page-organised monochrome framebuffer with a 2x2 scaled sprite row blitter.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Carries
//   --------+-----------+------------------------------------------------------
//   req     | in        | kind, row_bits, row_index, column_offset, page_offset,
//           |           | read_address
//   rsp     | out       | read_data (one result per read request only)
//
// A draw request is accepted, then one column byte is read-modify-written per cycle
// through the single memory port pair, and a final write-back ends the sweep.
// A clear request zeroes the whole store, one byte per cycle. A read request is
// accepted with its memory read, and its byte is loaded into the result register
// once that register has drained. After reset the same clearing sweep runs before
// the first request is taken. A stalled result holds the next read request in the
// controller, and no further request is taken until that result is accepted.
//
// ----------------------------------------------------------------------------
module scaled_sprite_blit_page_framebuffer import ssb_pkg::*; #(
  parameter int PAGES        = 8,
  parameter int COLUMNS      = 128,
  parameter int SPRITE_WIDTH = 32,
  parameter int SPRITE_ROWS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  ssb_req_if.sink   req,
  ssb_rsp_if.source rsp
);

  // The controller owns the request handshake and sequences the sweeps; the
  // datapath owns the store, the counters and the result register.
  ssb_cmd_t cmd;
  ssb_sts_t sts;

  ssb_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts)
  );

  // Each draw column is read from the store and written back OR-ed with the
  // two-row mask in the next cycle, so consecutive columns overlap in the pipeline.
  ssb_datapath #(
    .PAGES        (PAGES),
    .COLUMNS      (COLUMNS),
    .SPRITE_WIDTH (SPRITE_WIDTH),
    .SPRITE_ROWS  (SPRITE_ROWS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scaled sprite blit framebuffer. Requests are
// driven through the request channel, and every read byte returned on the
// result channel is compared with a behavioural copy of the page store.
// ----------------------------------------------------------------------------
module tb import ssb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the instance under test. It is passed down explicitly so that
  // the bench's own copy of the store always matches the one in the block.
  localparam int PAGES        = 8;
  localparam int COLUMNS      = 128;
  localparam int SPRITE_WIDTH = 32;
  localparam int SPRITE_ROWS  = 16;
  localparam int STORE_BYTES  = PAGES * COLUMNS;

  // Kind code that the block has no use for; it must be swallowed silently.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Minimum number of counted requests in each of the three idling phases.
  localparam int ITEMS_PER_PHASE = 667;
  // Length of the deliberate result back-pressure stretch.
  localparam int HOLD_CYCLES = 300;
  // A clear sweep of the whole store is the longest quiet spell, also straight
  // after reset, so the watchdog allows several times that.
  localparam int WATCHDOG_LIMIT = 12000;
  // Cycles to wait after the last result, a little beyond one draw request.
  localparam int TAIL_CYCLES = 80;

  // One request as the bench sees it. Rows of the directed table may carry the
  // read result typed in by hand; everything else is left to the predictor.
  typedef struct {
    logic [KIND_W-1:0]          kind;
    logic [ROW_W-1:0]           row_bits;
    logic [ROWIDX_W-1:0]        row_index;
    logic signed [COLOFF_W-1:0] column_offset;
    logic [PAGEOFF_W-1:0]       page_offset;
    logic [RADDR_W-1:0]         read_address;
    bit                         known;
    logic [BYTE_W-1:0]          known_data;
  } blit_req_t;

  logic clk = 1'b0;
  logic rst;

  ssb_req_if blit_req ();
  ssb_rsp_if blit_rsp ();

  scaled_sprite_blit_page_framebuffer #(
    .PAGES        (PAGES),
    .COLUMNS      (COLUMNS),
    .SPRITE_WIDTH (SPRITE_WIDTH),
    .SPRITE_ROWS  (SPRITE_ROWS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (blit_req),
    .rsp (blit_rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Behavioural copy of the page store and the bytes that reads still owe us.
  logic [BYTE_W-1:0] frame_model [STORE_BYTES];
  logic [BYTE_W-1:0] read_data_due [$];
  logic [BYTE_W-1:0] due_byte;
  int                mismatch_count = 0;
  int                quiet_cycles   = 0;

  // Idle percentages of each side, set by the stimulus for the current phase.
  int src_idle_pct  = 8;
  int sink_idle_pct = 57;
  // Raised by the stimulus to ask the result side for a long hold-off.
  bit hold_request  = 1'b0;

  // Directed table. The store is empty after reset, so the first reads are
  // zero; the hand-typed bytes elsewhere follow directly from the geometry:
  // one set pixel becomes a 2x2 block, i.e. two columns with two bits each.
  blit_req_t directed_reqs [25] = '{
    // Empty store after reset, at both ends of the address range.
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd0,    1'b1, 8'h00},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd1023, 1'b1, 8'h00},
    // Leftmost pixel of row 0 at the top-left corner: columns 0 and 1, bits 0 and 1.
    '{KIND_DRAW,  32'h8000_0000, 4'd0,  9'sd0,   3'd0, 10'd0,    1'b0, 8'h00},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd0,    1'b1, 8'h03},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd1,    1'b1, 8'h03},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd2,    1'b1, 8'h00},
    // Largest column offset, last row, last page: clipped away both right of the last column and below the last page.
    '{KIND_DRAW,  32'h0000_0001, 4'd15, 9'sd255, 3'd7, 10'd0,    1'b0, 8'h00},
    // Most negative column offset (-256): the whole row lies left of column 0.
    '{KIND_DRAW,  32'hFFFF_FFFF, 4'd0,  9'h100,  3'd7, 10'd0,    1'b0, 8'h00},
    // Offset -2 on the last page: the first pixel is lost, the rest lands in
    // columns 0..61 of page 7, bits 0 and 1.
    '{KIND_DRAW,  32'hFFFF_FFFF, 4'd0,  9'h1FE,  3'd7, 10'd0,    1'b0, 8'h00},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd896,  1'b1, 8'h03},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd957,  1'b1, 8'h03},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd958,  1'b1, 8'h00},
    // Row 4 from page 7 falls into page 8, which does not exist.
    '{KIND_DRAW,  32'hFFFF_FFFF, 4'd4,  9'sd0,   3'd7, 10'd0,    1'b0, 8'h00},
    // Row 3 from page 7 at column 100: bits 6 and 7, cut off at the right edge.
    '{KIND_DRAW,  32'hFFFF_FFFF, 4'd3,  9'sd100, 3'd7, 10'd0,    1'b0, 8'h00},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd1023, 1'b1, 8'hC0},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd996,  1'b1, 8'hC0},
    // An empty row must leave the store untouched.
    '{KIND_DRAW,  32'h0000_0000, 4'd15, 9'sd0,   3'd0, 10'd0,    1'b0, 8'h00},
    // Offset -1 and a mixed pattern; row 15 ends on the top bits of page 3.
    '{KIND_DRAW,  32'hA5A5_5A5A, 4'd15, 9'h1FF,  3'd0, 10'd0,    1'b0, 8'h00},
    '{KIND_DRAW,  32'h1234_5678, 4'd1,  9'sd37,  3'd2, 10'd0,    1'b0, 8'h00},
    // The unused kind with every field busy: no result, no change.
    '{KIND_UNUSED, 32'hFFFF_FFFF, 4'd15, 9'h1FF, 3'd7, 10'd1023, 1'b0, 8'h00},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd384,  1'b0, 8'h00},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd296,  1'b0, 8'h00},
    // Clear, then the corners read back as zero again.
    '{KIND_CLEAR, 32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd0,    1'b0, 8'h00},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd0,    1'b1, 8'h00},
    '{KIND_READ,  32'h0000_0000, 4'd0,  9'sd0,   3'd0, 10'd1023, 1'b1, 8'h00}
  };

  // ORs one 2x scaled sprite row into the model store. Each set pixel covers
  // two adjacent columns and two adjacent pixel rows; anything falling outside
  // the visible columns or below the last page is simply dropped.
  function automatic void blit_into_model(logic [ROW_W-1:0] bits, logic [ROWIDX_W-1:0] y,
                                          logic signed [COLOFF_W-1:0] col0,
                                          logic [PAGEOFF_W-1:0] page0);
    int col;
    int pix_row;
    int page;
    if (int'(y) >= SPRITE_ROWS) return;
    for (int x = 0; x < SPRITE_WIDTH; x++) begin
      // Pixels beyond the 32-bit field read as zero on wider sprites.
      if (SPRITE_WIDTH - 1 - x >= ROW_W) continue;
      if (!bits[SPRITE_WIDTH - 1 - x]) continue;
      for (int dx = 0; dx < 2; dx++) begin
        col = col0;
        col = col + 2 * x + dx;
        if (col < 0 || col >= COLUMNS) continue;
        for (int dy = 0; dy < 2; dy++) begin
          pix_row = int'(page0) * 8 + 2 * int'(y) + dy;
          page    = pix_row / 8;
          if (page < PAGES)
            frame_model[page * COLUMNS + col] |= BYTE_W'(1 << (pix_row % 8));
        end
      end
    end
  endfunction

  // Sprite rows with a spread of densities: sparse, solid, single pixel and
  // plain random, so that both clipping edges see set and clear pixels.
  function automatic logic [ROW_W-1:0] sprite_row_pattern();
    case ($urandom_range(4))
      0: begin
        return $urandom() & $urandom();
      end
      1: begin
        return '1;
      end
      2: begin
        return ROW_W'(1) << $urandom_range(ROW_W - 1);
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  // A request of the given kind with every other field random, so that the
  // fields a kind does not use still toggle through all their bits.
  function automatic blit_req_t random_req(logic [KIND_W-1:0] kind);
    blit_req_t r;
    r.kind          = kind;
    r.row_bits      = sprite_row_pattern();
    r.row_index     = ROWIDX_W'($urandom_range(15));
    r.column_offset = COLOFF_W'($urandom_range(511));
    r.page_offset   = PAGEOFF_W'($urandom_range(7));
    r.read_address  = RADDR_W'($urandom_range(1023));
    r.known         = 1'b0;
    r.known_data    = '0;
    return r;
  endfunction

  // Offers one request, after a random idle spell, and waits for the block to
  // take it. The model is updated at the accepting edge, which keeps it in
  // step with the block because requests are served strictly in order.
  task automatic issue_request(input blit_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      blit_req.valid <= 1'b0;
      @(posedge clk);
    end
    blit_req.valid         <= 1'b1;
    blit_req.kind          <= r.kind;
    blit_req.row_bits      <= r.row_bits;
    blit_req.row_index     <= r.row_index;
    blit_req.column_offset <= r.column_offset;
    blit_req.page_offset   <= r.page_offset;
    blit_req.read_address  <= r.read_address;
    @(posedge clk);
    while (!blit_req.ready) @(posedge clk);
    case (r.kind)
      KIND_CLEAR: begin
        foreach (frame_model[i]) frame_model[i] = '0;
      end
      KIND_DRAW: begin
        blit_into_model(r.row_bits, r.row_index, r.column_offset, r.page_offset);
      end
      KIND_READ: begin
        if (r.known)
          read_data_due.push_back(r.known_data);
        else if (int'(r.read_address) < STORE_BYTES)
          read_data_due.push_back(frame_model[r.read_address]);
        else
          read_data_due.push_back('0);
      end
      default: begin
      end
    endcase
  endtask

  // Result side. Ready is redrawn every cycle from the phase's idle rate,
  // except during the one long hold-off, which this process counts itself.
  initial begin
    blit_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        blit_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        blit_rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Every accepted result is matched against the oldest byte still owed.
  always @(posedge clk) begin
    if (!rst && blit_rsp.valid && blit_rsp.ready) begin
      if (read_data_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got read_data %02h",
                 $time, blit_rsp.read_data);
        mismatch_count++;
      end else begin
        due_byte = read_data_due.pop_front();
        if (blit_rsp.read_data !== due_byte) begin
          $display("%0t: read_data mismatch, expected %02h, got %02h",
                   $time, due_byte, blit_rsp.read_data);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles in which neither channel moves anything
  // means the block has hung or a result has gone missing.
  always @(posedge clk) begin
    if (rst || (blit_req.valid && blit_req.ready) || (blit_rsp.valid && blit_rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    blit_req_t r;
    int        counted;
    int        pick;
    int        col0;
    int        page0;
    int        first_row;
    int        reads;
    int        pg;
    int        col;

    // Every input is known from time zero; the model starts as the cleared store.
    rst                    <= 1'b1;
    blit_req.valid         <= 1'b0;
    blit_req.kind          <= KIND_CLEAR;
    blit_req.row_bits      <= '0;
    blit_req.row_index     <= '0;
    blit_req.column_offset <= '0;
    blit_req.page_offset   <= '0;
    blit_req.read_address  <= '0;
    foreach (frame_model[i]) frame_model[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The block runs its own clearing sweep after reset; the first request
    // simply waits for ready to come up.
    foreach (directed_reqs[i]) issue_request(directed_reqs[i]);

    // Back-pressure: the result side goes quiet for a long stretch while a run
    // of reads, with a few draws in between, keeps arriving. The result
    // register fills and the block has to hold off its request side.
    hold_request = 1'b1;
    for (int i = 0; i < 16; i++) begin
      r = random_req((i % 4 == 3) ? KIND_DRAW : KIND_READ);
      issue_request(r);
    end

    // Random part in three phases: sender busy and receiver sparse, the other
    // way round, then both flat out.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 8;
          sink_idle_pct = 57;
        end
        1: begin
          src_idle_pct  = 57;
          sink_idle_pct = 8;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          // A whole sprite, or its lower part, drawn at one position and then
          // read back from the area it covers. Most positions straddle an
          // edge of the screen; a few use the full signed offset range.
          if ($urandom_range(9) == 0)
            col0 = int'($urandom_range(511)) - 256;
          else
            col0 = int'($urandom_range(196)) - 68;
          page0     = $urandom_range(PAGES - 1);
          first_row = ($urandom_range(3) == 0) ? $urandom_range(SPRITE_ROWS - 1) : 0;
          for (int y = first_row; y < SPRITE_ROWS; y++) begin
            r               = random_req(KIND_DRAW);
            r.row_index     = ROWIDX_W'(y);
            r.column_offset = COLOFF_W'(col0);
            r.page_offset   = PAGEOFF_W'(page0);
            issue_request(r);
            counted++;
          end
          reads = $urandom_range(8, 2);
          for (int i = 0; i < reads; i++) begin
            pg = page0 + $urandom_range(3);
            if (pg >= PAGES) pg = $urandom_range(PAGES - 1);
            col = col0 + $urandom_range(2 * SPRITE_WIDTH - 1);
            if (col < 0 || col >= COLUMNS) col = $urandom_range(COLUMNS - 1);
            r              = random_req(KIND_READ);
            r.read_address = RADDR_W'(pg * COLUMNS + col);
            issue_request(r);
            counted++;
          end
        end else if (pick < 76) begin
          issue_request(random_req(KIND_READ));
          counted++;
        end else if (pick < 88) begin
          issue_request(random_req(KIND_DRAW));
          counted++;
        end else if (pick < 95) begin
          // Ignored by the block, so it is not counted towards the phase.
          issue_request(random_req(KIND_UNUSED));
        end else begin
          // Clears are kept rare: each one costs a full sweep of the store.
          issue_request(random_req(KIND_CLEAR));
          counted++;
        end
      end
    end

    blit_req.valid <= 1'b0;
    while (read_data_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
